@@ hdl/rns_pkg.sv @@
// Shared types and constants for the radius neighbor search block.
// Holds the point record, list sizes and the item and result codes.
// Used by every module under hdl; depends on nothing else.
package rns_pkg;

	// Capacity of the point list and the index and count widths it implies.
	localparam int POINTS = 32;
	localparam int IDX_W  = (POINTS > 1) ? $clog2(POINTS) : 1;
	localparam int CNT_W  = $clog2(POINTS + 1);

	// Input item kinds.
	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_LIST = 2'd1;
	localparam logic [1:0] KIND_ANY  = 2'd2;

	// Result types.
	localparam logic [1:0] RES_ACK   = 2'd0;
	localparam logic [1:0] RES_POINT = 2'd1;
	localparam logic [1:0] RES_SUM   = 2'd2;

	// One stored point, three signed Q8.8 coordinates.
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} point_t;

	// Control from the sequencer to the distance unit.
	typedef struct packed {
		logic advance;
		logic flush;
	} stage_ctl_t;

endpackage

@@ hdl/rns_point_mem.sv @@
// Point list storage: one write port and one registered read port.
// Depends on rns_pkg for the point record and index width.
module rns_point_mem
	import rns_pkg::*;
(
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  point_t           wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output point_t           rdata
);

	point_t mem [POINTS];
	point_t rdata_q;

	// Write on a load, read one entry per step of a query.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/rns_dist_unit.sv @@
// Shared distance unit: squares the three coordinate differences, registers
// them, then sums and compares against the squared radius.
// Depends on rns_pkg for the point record and the stage control struct.
module rns_dist_unit
	import rns_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  stage_ctl_t       ctl,
	input  logic             v_in,
	input  logic [IDX_W-1:0] idx_in,
	input  point_t           pt_in,
	input  point_t           origin,
	input  logic [31:0]      r2,
	output logic             v_s2,
	output logic [IDX_W-1:0] idx_s2,
	output point_t           pt_s2,
	output logic             in_range
);

	logic signed [16:0] dx, dy, dz;
	logic signed [33:0] px, py, pz;
	logic [31:0]        sqx_s2, sqy_s2, sqz_s2;
	logic               v_s2_q;
	logic [33:0]        d2;

	// Differences are 17 bits wide, so each square fits in 32 bits unsigned.
	always_comb begin
		dx = {pt_in.x[15], pt_in.x} - {origin.x[15], origin.x};
		dy = {pt_in.y[15], pt_in.y} - {origin.y[15], origin.y};
		dz = {pt_in.z[15], pt_in.z} - {origin.z[15], origin.z};
		px = dx * dx;
		py = dy * dy;
		pz = dz * dz;
	end

	// Stage valid bit, cleared when the sequencer drops work in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2_q <= 1'b0;
		end else if (ctl.flush) begin
			v_s2_q <= 1'b0;
		end else if (ctl.advance) begin
			v_s2_q <= v_in;
		end
	end

	// Squares and the point they belong to move together.
	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			sqx_s2 <= px[31:0];
			sqy_s2 <= py[31:0];
			sqz_s2 <= pz[31:0];
			idx_s2 <= idx_in;
			pt_s2  <= pt_in;
		end
	end

	// Exact compare of the Q16.16 squared distance with the squared radius.
	assign d2       = {2'b00, sqx_s2} + {2'b00, sqy_s2} + {2'b00, sqz_s2};
	assign in_range = (d2 <= {2'b00, r2});
	assign v_s2     = v_s2_q;

endmodule

@@ hdl/radius_neighbor_search_3d.sv @@
// Top level of the radius neighbor search: sequencer, point list and output register.
// Depends on rns_pkg, rns_point_mem and rns_dist_unit.
//
//   channel  valid      stall      payload
//   input    in_valid   in_stall   kind, start_new_list, coord_x/y/z, search_radius
//   output   out_valid  out_stall  result_type, point_index, point_x/y/z,
//                                  any_found, list_full, last_of_run
//
// A load yields its acknowledge in the next cycle.
// A query steps the shared distance unit over the stored points, one point per
// cycle while the output is not stalled, through a memory read stage and a
// squaring stage; the summary closes the run (alone for an empty list), and the
// next item is taken after it. An existence query stops at its first hit.
// Reset empties the list; the point memory itself is not cleared.
// An output stall freezes the whole query pipeline; input is taken only while idle.
module radius_neighbor_search_3d
	import rns_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic               start_new_list,
	input  logic signed [15:0] coord_x,
	input  logic signed [15:0] coord_y,
	input  logic signed [15:0] coord_z,
	input  logic [15:0]        search_radius,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         result_type,
	output logic [4:0]         point_index,
	output logic signed [15:0] point_x,
	output logic signed [15:0] point_y,
	output logic signed [15:0] point_z,
	output logic               any_found,
	output logic               list_full,
	output logic               last_of_run
);

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;
	logic             issue_q;
	logic             v_s1_q;
	logic [IDX_W-1:0] idx_s1_q;
	logic             list_mode_q;
	logic             found_q;
	point_t           origin_q;
	logic [31:0]      r2_q;

	logic               out_valid_q;
	logic [1:0]         type_q;
	logic [4:0]         index_q;
	logic signed [15:0] px_q, py_q, pz_q;
	logic               found_out_q;
	logic               full_q;
	logic               last_q;

	logic             en;
	logic             acc;
	logic             room;
	logic             we;
	logic [IDX_W-1:0] waddr;
	point_t           in_pt;
	point_t           rd_pt;
	logic             re;
	logic             drained;
	logic             match;
	stage_ctl_t       dctl;
	logic             v_s2;
	logic [IDX_W-1:0] idx_s2;
	point_t           pt_s2;
	logic             in_range;

	// Handshake and load decode.
	always_comb begin
		en      = !out_valid_q || !out_stall;
		in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
		acc     = in_valid && !in_stall;
		room    = start_new_list || (cnt_q < CNT_W'(POINTS));
		we      = acc && (kind == KIND_LOAD) && room;
		waddr   = start_new_list ? '0 : cnt_q[IDX_W-1:0];
		in_pt   = '{x: coord_x, y: coord_y, z: coord_z};
		re      = (state_q == ST_RUN) && issue_q && en;
		drained = !issue_q && !v_s1_q && !v_s2;
		match   = v_s2 && in_range;
		dctl.advance = (state_q == ST_RUN) && en;
		dctl.flush   = (state_q == ST_RUN) && en && (drained || (match && !list_mode_q));
	end

	rns_point_mem u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (in_pt),
		.re    (re),
		.raddr (idx_q),
		.rdata (rd_pt)
	);

	rns_dist_unit u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (dctl),
		.v_in     (v_s1_q),
		.idx_in   (idx_s1_q),
		.pt_in    (rd_pt),
		.origin   (origin_q),
		.r2       (r2_q),
		.v_s2     (v_s2),
		.idx_s2   (idx_s2),
		.pt_s2    (pt_s2),
		.in_range (in_range)
	);

	// Sequencer, list count and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			issue_q     <= 1'b0;
			v_s1_q      <= 1'b0;
			idx_s1_q    <= '0;
			list_mode_q <= 1'b0;
			found_q     <= 1'b0;
			origin_q    <= '0;
			r2_q        <= '0;
			out_valid_q <= 1'b0;
			type_q      <= RES_ACK;
			index_q     <= '0;
			px_q        <= '0;
			py_q        <= '0;
			pz_q        <= '0;
			found_out_q <= 1'b0;
			full_q      <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			// A transfer on the output empties the register unless refilled below.
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						case (kind) inside
							KIND_LOAD: begin
								out_valid_q <= 1'b1;
								type_q      <= RES_ACK;
								index_q     <= room ? 5'(waddr) : 5'd0;
								px_q        <= coord_x;
								py_q        <= coord_y;
								pz_q        <= coord_z;
								found_out_q <= 1'b0;
								full_q      <= !room;
								last_q      <= 1'b1;
								if (start_new_list) begin
									cnt_q <= CNT_W'(1);
								end else if (room) begin
									cnt_q <= cnt_q + 1'b1;
								end
							end
							KIND_LIST, KIND_ANY: begin
								list_mode_q <= (kind == KIND_LIST);
								origin_q    <= in_pt;
								r2_q        <= 32'(search_radius) * 32'(search_radius);
								idx_q       <= '0;
								issue_q     <= (cnt_q != '0);
								v_s1_q      <= 1'b0;
								found_q     <= 1'b0;
								state_q     <= ST_RUN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RUN: begin
					if (en) begin
						// Read stage: issue the next stored point.
						v_s1_q   <= issue_q;
						idx_s1_q <= idx_q;
						if (issue_q) begin
							idx_q <= idx_q + 1'b1;
							if ({1'b0, idx_q} == cnt_q - 1'b1) begin
								issue_q <= 1'b0;
							end
						end
						if (drained) begin
							// Every point checked: close the run with the summary.
							out_valid_q <= 1'b1;
							type_q      <= RES_SUM;
							index_q     <= '0;
							px_q        <= '0;
							py_q        <= '0;
							pz_q        <= '0;
							found_out_q <= found_q;
							full_q      <= 1'b0;
							last_q      <= 1'b1;
							state_q     <= ST_IDLE;
						end else if (match) begin
							if (list_mode_q) begin
								out_valid_q <= 1'b1;
								type_q      <= RES_POINT;
								index_q     <= 5'(idx_s2);
								px_q        <= pt_s2.x;
								py_q        <= pt_s2.y;
								pz_q        <= pt_s2.z;
								found_out_q <= 1'b0;
								full_q      <= 1'b0;
								last_q      <= 1'b0;
								found_q     <= 1'b1;
							end else begin
								// Existence query stops at the first hit.
								out_valid_q <= 1'b1;
								type_q      <= RES_SUM;
								index_q     <= '0;
								px_q        <= '0;
								py_q        <= '0;
								pz_q        <= '0;
								found_out_q <= 1'b1;
								full_q      <= 1'b0;
								last_q      <= 1'b1;
								issue_q     <= 1'b0;
								v_s1_q      <= 1'b0;
								state_q     <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign result_type = type_q;
	assign point_index = index_q;
	assign point_x     = px_q;
	assign point_y     = py_q;
	assign point_z     = pz_q;
	assign any_found   = found_out_q;
	assign list_full   = full_q;
	assign last_of_run = last_q;

endmodule
